@@ rtl/core/cstok_pkg.sv @@
// shared types, codes and byte classes for the csv stream tokenizer
// no dependencies
package cstok_pkg;

	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ROW_END   = 2'd2;

	localparam logic [7:0] DQ_BYTE    = 8'h22;
	localparam logic [7:0] SQ_BYTE    = 8'h27;
	localparam logic [7:0] BS_BYTE    = 8'h5c;
	localparam logic [7:0] SPACE_BYTE = 8'h20;

	localparam logic [2:0] REG_SEPARATOR   = 3'd0;
	localparam logic [2:0] REG_ALLOW_DQ    = 3'd1;
	localparam logic [2:0] REG_ALLOW_SQ    = 3'd2;
	localparam logic [2:0] REG_BACKSLASH   = 3'd3;
	localparam logic [2:0] REG_DOUBLED_ESC = 3'd4;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0] separator;
		logic       allow_dq;
		logic       allow_sq;
		logic       backslash_esc;
		logic       doubled_esc;
	} cfg_t;

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b <= 8'h1f) || (b >= 8'h7f && b <= 8'h9f);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b >= 8'h09 && b <= 8'h0d) || b == 8'h20 || b == 8'h85 || b == 8'ha0;
	endfunction

endpackage

@@ rtl/core/cstok_core.sv @@
// tokenizer state flags and per-request result logic
// depends on cstok_pkg
module cstok_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cstok_pkg::cfg_t      cfg,
	input  logic                 accept,
	input  logic                 kind,
	input  logic [7:0]           in_byte,
	output logic [1:0]           push_n,
	output cstok_pkg::res_t      res0,
	output cstok_pkg::res_t      res1
);

	typedef struct packed {
		logic in_quote;
		logic quote_is_single;
		logic escape_pending;
		logic close_quote_pending;
		logic text_seen;
		logic space_pending;
		logic raw_field_nonempty;
		logic row_nonempty;
	} st_t;

	st_t st_q;
	st_t st_nxt;

	logic       do_app;
	logic [7:0] app_byte;
	logic       do_fe;
	logic       do_re;
	logic       emit_space;
	logic       emit_data;

	always_comb begin
		logic       do_out;
		logic [7:0] qc;
		st_nxt   = st_q;
		do_app   = 1'b0;
		app_byte = in_byte;
		do_fe    = 1'b0;
		do_re    = 1'b0;
		do_out   = 1'b0;
		qc       = st_q.quote_is_single ? cstok_pkg::SQ_BYTE : cstok_pkg::DQ_BYTE;

		if (kind) begin
			do_fe  = st_q.raw_field_nonempty;
			do_re  = st_q.raw_field_nonempty | st_q.row_nonempty;
			st_nxt = '0;
		end else if (st_q.in_quote) begin
			if (st_q.escape_pending) begin
				st_nxt.escape_pending = 1'b0;
				do_app = 1'b1;
			end else if (st_q.close_quote_pending) begin
				st_nxt.close_quote_pending = 1'b0;
				if (in_byte == qc) begin
					do_app = 1'b1;
				end else begin
					st_nxt.in_quote = 1'b0;
					do_out = 1'b1;
				end
			end else if (in_byte == cstok_pkg::BS_BYTE && cfg.backslash_esc) begin
				st_nxt.escape_pending = 1'b1;
			end else if (in_byte == qc) begin
				if (cfg.doubled_esc) begin
					st_nxt.close_quote_pending = 1'b1;
				end else begin
					st_nxt.in_quote = 1'b0;
				end
			end else begin
				do_app = 1'b1;
			end
		end else begin
			do_out = 1'b1;
		end

		// bytes outside a quoted section
		if (do_out) begin
			if (in_byte != cfg.separator && cstok_pkg::is_ctrl(in_byte)) begin
				do_fe = 1'b1;
				do_re = 1'b1;
				st_nxt.text_seen          = 1'b0;
				st_nxt.space_pending      = 1'b0;
				st_nxt.raw_field_nonempty = 1'b0;
				st_nxt.row_nonempty       = 1'b0;
			end else if ((cfg.allow_dq && in_byte == cstok_pkg::DQ_BYTE) ||
				(cfg.allow_sq && in_byte == cstok_pkg::SQ_BYTE)) begin
				st_nxt.in_quote        = 1'b1;
				st_nxt.quote_is_single = (in_byte == cstok_pkg::SQ_BYTE);
			end else if (in_byte == cfg.separator) begin
				do_fe = 1'b1;
				st_nxt.text_seen          = 1'b0;
				st_nxt.space_pending      = 1'b0;
				st_nxt.raw_field_nonempty = 1'b0;
				st_nxt.row_nonempty       = 1'b1;
			end else begin
				do_app = 1'b1;
			end
		end

		// whitespace simplification
		emit_space = 1'b0;
		emit_data  = 1'b0;
		if (do_app) begin
			st_nxt.raw_field_nonempty = 1'b1;
			if (cstok_pkg::is_space(app_byte)) begin
				if (st_q.text_seen) begin
					st_nxt.space_pending = 1'b1;
				end
			end else begin
				emit_space = st_q.space_pending;
				emit_data  = 1'b1;
				st_nxt.space_pending = 1'b0;
				st_nxt.text_seen     = 1'b1;
			end
		end
	end

	always_comb begin
		res0   = '0;
		res1   = '0;
		push_n = 2'd0;
		if (do_app) begin
			if (emit_space) begin
				res0   = '{kind: cstok_pkg::KIND_DATA, data: cstok_pkg::SPACE_BYTE, last: 1'b0};
				res1   = '{kind: cstok_pkg::KIND_DATA, data: app_byte, last: 1'b1};
				push_n = 2'd2;
			end else if (emit_data) begin
				res0   = '{kind: cstok_pkg::KIND_DATA, data: app_byte, last: 1'b1};
				push_n = 2'd1;
			end
		end else if (do_fe && do_re) begin
			res0   = '{kind: cstok_pkg::KIND_FIELD_END, data: 8'h00, last: 1'b0};
			res1   = '{kind: cstok_pkg::KIND_ROW_END, data: 8'h00, last: 1'b1};
			push_n = 2'd2;
		end else if (do_fe) begin
			res0   = '{kind: cstok_pkg::KIND_FIELD_END, data: 8'h00, last: 1'b1};
			push_n = 2'd1;
		end else if (do_re) begin
			res0   = '{kind: cstok_pkg::KIND_ROW_END, data: 8'h00, last: 1'b1};
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind |=> st_q == '0)
		else $error("state not cleared after end of stream");
	a_esc_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.escape_pending || st_q.close_quote_pending) |-> st_q.in_quote)
		else $error("escape or close pending outside quotes");
	a_space_needs_text: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.space_pending |-> st_q.text_seen && st_q.raw_field_nonempty)
		else $error("space pending without field text");

endmodule

@@ rtl/core/cstok_outq.sv @@
// small result queue between the tokenizer logic and the output channel
// depends on cstok_pkg
module cstok_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  cstok_pkg::res_t      res0,
	input  cstok_pkg::res_t      res1,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cstok_pkg::res_t      head
);

	localparam int PW = $clog2(cstok_pkg::QUEUE_DEPTH);
	localparam int CW = PW + 1;

	cstok_pkg::res_t mem_q [cstok_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];
	// room for two results is needed before the next request
	assign full      = count_q > CW'(cstok_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(cstok_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> !full)
		else $error("push while queue full");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!pop && push_n == 2'd0 |=> $stable(count_q))
		else $error("queue count moved without push or pop");

endmodule

@@ rtl/core/csv_stream_tokenizer_unit.sv @@
// csv stream tokenizer top level: config registers, tokenizer, result queue
// depends on cstok_pkg, cstok_core, cstok_outq
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | kind, in_byte
//   out     | output    | out_valid / out_stall | out_kind, out_byte, last
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one input request per cycle while in_stall is low; each request yields
// zero, one or two results; results leave at one per cycle while out_stall
// is low, from a four-entry queue; in_stall rises while fewer than two
// queue entries are free, so a request waits while three or more are held
// reset clears all tokenizer state and loads the register reset values
module csv_stream_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cstok_pkg::cfg_t cfg_q;
	cstok_pkg::res_t res0;
	cstok_pkg::res_t res1;
	cstok_pkg::res_t head;
	logic [1:0]      push_n;
	logic            full;
	logic            accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{separator: 8'd44, allow_dq: 1'b1, allow_sq: 1'b0,
				backslash_esc: 1'b0, doubled_esc: 1'b1};
		end else if (cfg_we) begin
			unique case (cfg_index)
				cstok_pkg::REG_SEPARATOR:   cfg_q.separator     <= cfg_data;
				cstok_pkg::REG_ALLOW_DQ:    cfg_q.allow_dq      <= cfg_data[0];
				cstok_pkg::REG_ALLOW_SQ:    cfg_q.allow_sq      <= cfg_data[0];
				cstok_pkg::REG_BACKSLASH:   cfg_q.backslash_esc <= cfg_data[0];
				cstok_pkg::REG_DOUBLED_ESC: cfg_q.doubled_esc   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cstok_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.kind    (kind),
		.in_byte (in_byte),
		.push_n  (push_n),
		.res0    (res0),
		.res1    (res1)
	);

	cstok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (accept ? push_n : 2'd0),
		.res0      (res0),
		.res1      (res1),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_kind = head.kind;
	assign out_byte = head.data;
	assign last     = head.last;

endmodule
